[design/gpcm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcm_pkg
// Shared constants, types and helpers for the grid pattern cell marker.
// ----------------------------------------------------------------------------
package gpcm_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int ADDR_W      = $clog2(MAX_WIDTH);
   localparam int COL_W       = 8;
   localparam int GEOM_W      = 9;
   localparam int CNT_W       = 4;
   localparam int WIN_COLS    = 2;
   localparam int OUT_DEPTH   = 3;
   localparam int PTR_W       = $clog2(OUT_DEPTH);
   localparam int QCNT_W      = $clog2(OUT_DEPTH + 1);
   localparam int CSR_IDX_W   = 2;
   localparam int STORE_W     = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INNER   = 2'd2;

   localparam logic [GEOM_W-1:0] GEOM_MIN       = 9'd3;
   localparam logic [GEOM_W-1:0] GEOM_MAX       = 9'd256;
   localparam logic [GEOM_W-1:0] WIDTH_LIMIT    = GEOM_W'(MAX_WIDTH);
   localparam logic [GEOM_W-1:0] RST_GRID_GEOM  = 9'd160;
   localparam logic [CNT_W-1:0]  RST_MIN_INNER  = 4'd8;
   localparam logic [COL_W-1:0]  EDGE_MARGIN    = 8'd2;

   typedef struct packed {
      logic [COL_W-1:0] row;
      logic [COL_W-1:0] col;
   } mark_type;

   function automatic logic [1:0] bits3(input logic [2:0] v);
      return {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
   endfunction

   function automatic logic [GEOM_W-1:0] clamp_geom(input logic [GEOM_W-1:0] v);
      logic [GEOM_W-1:0] r;
      r = v;
      if (v < GEOM_MIN) begin
         r = GEOM_MIN;
      end else if (v > GEOM_MAX) begin
         r = GEOM_MAX;
      end
      return r;
   endfunction

endpackage

[design/gpcm_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gpcm_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/gpcm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gpcm_cell
// One column of the 3x3 window: holds three non-edge flags, passes them on
// to the next cell and reports how many are set.
// ----------------------------------------------------------------------------
module gpcm_cell
   import gpcm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  logic [2:0] col_in,
   output logic [2:0] col_out,
   output logic [1:0] ones_out
);

   logic [2:0] col_ff;
   logic [2:0] col_in_w;

   assign col_in_w = shift_en ? col_in : col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_w;
      end
   end

   assign col_out  = col_ff;
   assign ones_out = bits3(col_ff);

endmodule

[design/grid_pattern_cell_marker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_pattern_cell_marker
// 3x3 binary rank filter over a raster grid; emits the position of every
// interior non-edge cell with enough non-edge cells in its 3x3 window.
//
//   channel | direction | handshake             | payload
//   req     | in        | req_tvalid/req_tready | tdata: is_edge_kind; tuser: frame_start
//   rsp     | out       | rsp_tvalid/rsp_tready | tdata: mark_col, mark_row
//   csr     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// One cell per cycle while req_tready is high; a mark is formed in stage B and
// written into the result queue. The line store RAM is read on accept and
// written in the next cycle, with a bypass for back-to-back cells at the same column.
// Reset clears all the store valid bits directly; no clearing pass.
// A three-entry result queue absorbs rsp stalls; req_tready drops only when
// the queue plus the cell in flight could fill it.
// ----------------------------------------------------------------------------
module grid_pattern_cell_marker
   import gpcm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [0] is_edge_kind
   input  logic                 req_tuser,   // [0] frame_start
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [7:0] mark_col, [15:8] mark_row
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GEOM_W-1:0]    csr_data
);

   // configuration
   logic [GEOM_W-1:0] grid_width_ff, grid_height_ff;
   logic [CNT_W-1:0]  min_inner_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= RST_GRID_GEOM;
         grid_height_ff <= RST_GRID_GEOM;
         min_inner_ff   <= RST_MIN_INNER;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_data;
            CSR_GRID_HEIGHT: grid_height_ff <= csr_data;
            CSR_MIN_INNER:   min_inner_ff   <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // stage A: position of the arriving cell
   logic              accept;
   logic              inner_a;
   logic [GEOM_W-1:0] w_eff, h_eff, w_clamp;
   logic [COL_W-1:0]  col_ff, row_ff, col_in, row_in;
   logic [GEOM_W-1:0] col_a, row_a, col_step, row_step;
   logic [COL_W-1:0]  c_a, r_a;

   assign accept  = req_tvalid && req_tready;
   assign inner_a = ~req_tdata[0];
   assign w_clamp = clamp_geom(grid_width_ff);
   assign w_eff   = (w_clamp > WIDTH_LIMIT) ? WIDTH_LIMIT : w_clamp;
   assign h_eff   = clamp_geom(grid_height_ff);

   always_comb begin
      col_a = req_tuser ? '0 : {1'b0, col_ff};
      row_a = req_tuser ? '0 : {1'b0, row_ff};
      if (col_a >= w_eff) begin
         col_a = '0;
         row_a = row_a + 1'b1;
      end
      if (row_a >= h_eff) begin
         row_a = '0;
      end
   end

   assign c_a      = col_a[COL_W-1:0];
   assign r_a      = row_a[COL_W-1:0];
   assign col_step = {1'b0, c_a} + 1'b1;
   assign row_step = {1'b0, r_a} + 1'b1;

   always_comb begin
      if (col_step >= w_eff) begin
         col_in = '0;
         row_in = (row_step >= h_eff) ? '0 : row_step[COL_W-1:0];
      end else begin
         col_in = col_step[COL_W-1:0];
         row_in = r_a;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // line store: bit 1 two rows up, bit 0 one row up
   logic                  b_valid_ff;
   logic [COL_W-1:0]      b_col_ff, b_row_ff;
   logic                  b_inner_ff;
   logic                  b_fwd_hit_ff, b_rvalid_ff;
   logic [STORE_W-1:0]    b_fwd_data_ff;
   logic [STORE_W-1:0]    rd_data, store_b, wr_data;
   logic [MAX_WIDTH-1:0]  valid_ff;

   gpcm_ram #(
      .WIDTH (STORE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (b_valid_ff),
      .wr_addr (b_col_ff[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (c_a[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= accept;
         if (b_valid_ff) begin
            valid_ff[b_col_ff[ADDR_W-1:0]] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         b_col_ff      <= c_a;
         b_row_ff      <= r_a;
         b_inner_ff    <= inner_a;
         b_fwd_hit_ff  <= b_valid_ff && (b_col_ff == c_a);
         b_fwd_data_ff <= wr_data;
         b_rvalid_ff   <= valid_ff[c_a[ADDR_W-1:0]];
      end
   end

   // stage B: window and decision
   logic [2:0]       newcol;
   logic [2:0]       chain_col [WIN_COLS+1];
   logic [1:0]       ones [WIN_COLS];
   logic [CNT_W-1:0] count_b;
   logic             hit_b;

   assign store_b = b_fwd_hit_ff ? b_fwd_data_ff :
                    (b_rvalid_ff ? rd_data : '0);
   assign newcol  = {store_b[1], store_b[0], b_inner_ff};
   assign wr_data = {store_b[0], b_inner_ff};
   assign chain_col[0] = newcol;

   for (genvar i = 0; i < WIN_COLS; i++) begin : g_cell
      gpcm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (b_valid_ff),
         .col_in   (chain_col[i]),
         .col_out  (chain_col[i+1]),
         .ones_out (ones[i])
      );
   end

   always_comb begin
      count_b = CNT_W'(bits3(newcol));
      for (int i = 0; i < WIN_COLS; i++) begin
         count_b = count_b + CNT_W'(ones[i]);
      end
   end

   assign hit_b = (b_col_ff >= EDGE_MARGIN) && (b_row_ff >= EDGE_MARGIN) &&
                  chain_col[1][1] && (count_b >= min_inner_ff);

   // result queue
   mark_type          q_ff [OUT_DEPTH];
   mark_type          mark_b;
   logic [PTR_W-1:0]  head_ff, tail_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              push, pop;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(OUT_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign mark_b.col = b_col_ff - 1'b1;
   assign mark_b.row = b_row_ff - 1'b1;
   assign push       = b_valid_ff && hit_b;
   assign pop        = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            tail_ff <= ptr_next(tail_ff);
         end
         if (pop) begin
            head_ff <= ptr_next(head_ff);
         end
         count_ff <= count_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= mark_b;
      end
   end

   assign req_tready = ((QCNT_W+1)'(count_ff) + (QCNT_W+1)'(b_valid_ff))
                       < (QCNT_W+1)'(OUT_DEPTH);
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = q_ff[head_ff];

   // checks
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(OUT_DEPTH))
      else $error("result queue count out of range");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff < QCNT_W'(OUT_DEPTH))
      else $error("result queue overflow");

   assert property (@(posedge clock) disable iff (reset)
      push |-> (b_col_ff >= EDGE_MARGIN) && (b_row_ff >= EDGE_MARGIN))
      else $error("mark raised for a border cell");

   assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == tail_ff)
      else $error("result queue pointers disagree with count");

endmodule

[tb/grid_pattern_cell_marker_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_pattern_cell_marker_tb
// Streams raster grids of edge/non-edge cells into the marker and checks
// every emitted mark, field by field, against a cycle-free scoreboard model
// of the 3x3 rank filter. The run walks through several geometry and
// threshold settings, including clamped and out-of-range values, and varies
// input bursts, output stalls and one long output hold.
// ----------------------------------------------------------------------------
module grid_pattern_cell_marker_tb;
   import gpcm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int CELL_TARGET = 1850;

   typedef enum logic [1:0] {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_type;
   typedef enum logic {PACE_FULL, PACE_BURSTY} pace_type;

   typedef struct packed {
      logic is_edge;
      logic grid_start;
   } cell_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [7:0]           req_tdata = '0;   // [0] is_edge_kind
   logic                 req_tuser = 1'b0; // [0] frame_start
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;        // [7:0] mark_col, [15:8] mark_row
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [GEOM_W-1:0]    csr_data = '0;

   grid_pattern_cell_marker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   cell_type cell_q[$];
   mark_type mark_q[$];

   stall_type stall_mode = STALL_NONE;
   pace_type  pace = PACE_FULL;
   int        hold_asked = 0;

   int mismatch_count = 0;
   int cells_queued = 0;
   int cells_taken = 0;
   int marks_seen = 0;
   int regs_written = 0;
   int setting_count = 0;

   // scoreboard model state
   logic              upper_row [MAX_WIDTH];
   logic              middle_row [MAX_WIDTH];
   logic [5:0]        window_bits;
   logic [COL_W-1:0]  col_pos;
   logic [COL_W-1:0]  row_pos;
   logic [GEOM_W-1:0] width_reg;
   logic [GEOM_W-1:0] height_reg;
   logic [CNT_W-1:0]  thr_reg;

   initial begin
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout: run did not complete");
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic report_mismatch(input string what);
      if (mismatch_count < 50) begin
         $display("ERROR %0t: %s", $time, what);
      end
      mismatch_count++;
   endtask

   function automatic logic [GEOM_W-1:0] fit_geom(input logic [GEOM_W-1:0] v);
      logic [GEOM_W-1:0] r;
      r = (v < 9'd3) ? 9'd3 : ((v > 9'd256) ? 9'd256 : v);
      return r;
   endfunction

   function automatic void predict_marks(input logic is_edge, input logic grid_start);
      logic [GEOM_W-1:0] w;
      logic [GEOM_W-1:0] h;
      logic              inner;
      logic [2:0]        newcol;
      int                count;
      mark_type          m;
      w = fit_geom(width_reg);
      h = fit_geom(height_reg);
      if (w > WIDTH_LIMIT) begin
         w = WIDTH_LIMIT;
      end
      inner = ~is_edge;
      if (grid_start) begin
         col_pos = '0;
         row_pos = '0;
      end
      if ({1'b0, col_pos} >= w) begin
         col_pos = '0;
         row_pos = row_pos + 8'd1;
      end
      if ({1'b0, row_pos} >= h) begin
         row_pos = '0;
      end
      newcol = {upper_row[col_pos], middle_row[col_pos], inner};
      count = $countones(window_bits) + $countones(newcol);
      if (col_pos >= 8'd2 && row_pos >= 8'd2 && window_bits[1] && count >= int'(thr_reg)) begin
         m.col = col_pos - 8'd1;
         m.row = row_pos - 8'd1;
         mark_q.push_back(m);
      end
      upper_row[col_pos] = middle_row[col_pos];
      middle_row[col_pos] = inner;
      window_bits = {window_bits[2:0], newcol};
      if ({1'b0, col_pos} + 9'd1 >= w) begin
         col_pos = '0;
         row_pos = ({1'b0, row_pos} + 9'd1 >= h) ? 8'd0 : row_pos + 8'd1;
      end else begin
         col_pos = col_pos + 8'd1;
      end
   endfunction

   always @(posedge clock) begin : feeder
      cell_type next_cell;
      int       gap_left;
      int       burst_left;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tuser <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (cell_q.size() != 0) begin
            next_cell = cell_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {7'd0, next_cell.is_edge};
            req_tuser <= next_cell.grid_start;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               if (pace == PACE_BURSTY) begin
                  gap_left = $urandom_range(1, 8);
               end
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : sink
      int hold_left;
      int hold_seen;
      int tick;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left = 0;
         hold_seen = 0;
         tick = 0;
      end else begin
         tick++;
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (stall_mode)
               STALL_NONE: begin
                  rsp_tready <= 1'b1;
               end
               STALL_RANDOM: begin
                  rsp_tready <= ($urandom_range(0, 2) != 0);
               end
               default: begin
                  rsp_tready <= ((tick % 7) > 1);
               end
            endcase
         end
      end
   end

   always @(posedge clock) begin : scoreboard
      mark_type got;
      mark_type want;
      if (reset) begin
         for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_row[i] = 1'b0;
            middle_row[i] = 1'b0;
         end
         window_bits = '0;
         col_pos = '0;
         row_pos = '0;
         width_reg = RST_GRID_GEOM;
         height_reg = RST_GRID_GEOM;
         thr_reg = RST_MIN_INNER;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_GRID_WIDTH: width_reg = csr_data;
               CSR_GRID_HEIGHT: height_reg = csr_data;
               CSR_MIN_INNER: thr_reg = csr_data[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            predict_marks(req_tdata[0], req_tuser);
            cells_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (mark_q.size() == 0) begin
               report_mismatch($sformatf("mark col %0d row %0d with nothing expected",
                                         got.col, got.row));
            end else begin
               want = mark_q.pop_front();
               if (got.col != want.col) begin
                  report_mismatch($sformatf("mark_col %0d, expected %0d", got.col, want.col));
               end
               if (got.row != want.row) begin
                  report_mismatch($sformatf("mark_row %0d, expected %0d", got.row, want.row));
               end
               marks_seen++;
            end
         end
      end
   end

   task automatic program_regs(input logic [GEOM_W-1:0] w, input logic [GEOM_W-1:0] h,
                               input logic [GEOM_W-1:0] thr, input bit poke_spare);
      logic [CSR_IDX_W-1:0] idx [4];
      logic [GEOM_W-1:0]    val [4];
      int                   n;
      idx = '{CSR_GRID_WIDTH, CSR_GRID_HEIGHT, CSR_MIN_INNER, CSR_SPARE};
      val = '{w, h, thr, GEOM_W'($urandom)};
      n = poke_spare ? 4 : 3;
      for (int i = 0; i < n; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      regs_written += n;
      setting_count++;
   endtask

   task automatic queue_grid(input int cells, input int edge_pct, input bit lead_start,
                             input int noise_pct);
      cell_type c;
      for (int i = 0; i < cells; i++) begin
         c.is_edge = ($urandom_range(0, 99) < edge_pct);
         c.grid_start = (i == 0) ? lead_start : ($urandom_range(0, 99) < noise_pct);
         cell_q.push_back(c);
      end
      cells_queued += cells;
   endtask

   task automatic drain(input int cap);
      int n;
      n = 0;
      do begin
         @(posedge clock);
         n++;
      end while ((cell_q.size() != 0 || req_tvalid || mark_q.size() != 0) && n < cap);
   endtask

   task automatic settle();
      drain(400_000);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [GEOM_W-1:0] pick_geom(input int hi);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) begin
         return GEOM_W'($urandom_range(0, 2));
      end else if (sel < 15) begin
         return GEOM_W'($urandom_range(257, 511));
      end
      return GEOM_W'($urandom_range(3, hi));
   endfunction

   initial begin : stimulus
      int                pct [4];
      cell_type          c;
      logic [GEOM_W-1:0] w;
      logic [GEOM_W-1:0] h;
      logic [CNT_W-1:0]  thr;
      int                cells;
      int                frames;
      pct = '{3, 30, 60, 95};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 5x5 grid, full threshold, one edge cell at (3,3)
      program_regs(9'd5, 9'd5, 9'd9, 1'b1);
      for (int i = 0; i < 25; i++) begin
         c.is_edge = (i == 18);
         c.grid_start = (i == 0);
         cell_q.push_back(c);
      end
      cells_queued += 25;
      settle();

      // hold the output long enough to back up the input
      program_regs(9'd8, 9'd8, 9'd0, 1'b0);
      hold_asked <= hold_asked + 1;
      queue_grid(64, 10, 1'b1, 0);
      queue_grid(64, 10, 1'b1, 0);
      settle();

      pace <= PACE_BURSTY;
      stall_mode <= STALL_RANDOM;
      program_regs(9'h1FF, 9'd3, 9'd7, 1'b0);
      queue_grid(768, 25, 1'b1, 0);
      settle();

      // tall grid left unfinished, so the next setting shrinks it mid-grid
      stall_mode <= STALL_PERIODIC;
      program_regs(9'd0, 9'd256, {5'h1F, 4'd6}, 1'b0);
      queue_grid(400, 20, 1'b1, 0);
      settle();

      while (cells_queued < CELL_TARGET) begin
         w = pick_geom(12);
         h = pick_geom(8);
         thr = ($urandom_range(0, 9) < 7) ? CNT_W'($urandom_range(4, 9))
                                          : CNT_W'($urandom_range(0, 15));
         stall_mode <= stall_type'($urandom_range(0, 2));
         pace <= pace_type'($urandom_range(0, 1));
         program_regs(w, h, {5'($urandom), thr}, 1'b0);
         frames = $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            cells = int'(fit_geom(w)) * int'(fit_geom(h));
            if (cells > 150) begin
               cells = 150;
            end
            if ($urandom_range(0, 99) < 15) begin
               cells = $urandom_range(1, cells);
            end
            queue_grid(cells, pct[$urandom_range(0, 3)], $urandom_range(0, 9) != 0,
                       ($urandom_range(0, 9) < 3) ? 2 : 0);
            if ($urandom_range(0, 4) == 0) begin
               drain(400_000);
            end
         end
         settle();
      end

      drain(5000);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mark_q.size() != 0) begin
         report_mismatch($sformatf("%0d expected marks never arrived", mark_q.size()));
      end
      $display("Run covered %0d cells over %0d settings (%0d register writes), %0d marks.",
               cells_taken, setting_count, regs_written, marks_seen);
      $display("Grids up to 256 wide and 256 tall, thresholds 0 to 15, bursts and stalls.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[filelist.f]
design/gpcm_pkg.sv
design/gpcm_ram.sv
design/gpcm_cell.sv
design/grid_pattern_cell_marker.sv
tb/grid_pattern_cell_marker_tb.sv
